// ===== hdl/double_hash_table_assert.svh =====
// assertion macros for the double hash table
// expects clk_i and rst_ni in the including module
`ifndef DOUBLE_HASH_TABLE_ASSERT_SVH
`define DOUBLE_HASH_TABLE_ASSERT_SVH

// property must hold at every clock edge out of reset
`define DHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define DHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dht_pkg.sv =====
// shared types and constants for the double hash table
// no dependencies
package dht_pkg;

  localparam int KeyW    = 31;
  localparam int KindW   = 2;
  localparam int StatusW = 2;
  localparam int SlotW   = 4;

  localparam int DhtSlots   = 16;
  localparam int DhtStepMod = 7;

  localparam logic [KindW-1:0] KindInsert = 2'd0;
  localparam logic [KindW-1:0] KindDelete = 2'd1;
  localparam logic [KindW-1:0] KindSearch = 2'd2;

  localparam logic [StatusW-1:0] StDone    = 2'd0;
  localparam logic [StatusW-1:0] StMissing = 2'd1;
  localparam logic [StatusW-1:0] StFull    = 2'd2;

  // divisor select of the shared remainder unit
  localparam logic SelSlots = 1'b0;
  localparam logic SelStep  = 1'b1;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_MODK,
    S_MODX,
    S_MODS,
    S_STEP,
    S_CHK,
    S_RESP
  } state_e;

endpackage

// ===== hdl/dht_ram.sv =====
// generic single-port ram with registered read
// no dependencies
module dht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/dht_mod_unit.sv =====
// shared remainder unit: reciprocal multiply by one of two constant divisors,
// issue one cycle, remainder valid the next
// depends on dht_pkg
module dht_mod_unit
  import dht_pkg::*;
#(
  parameter int DIV_A = DhtSlots,
  parameter int DIV_B = DhtStepMod,
  parameter int RW    = ($clog2(DIV_A) > $clog2(DIV_B)) ? $clog2(DIV_A) : $clog2(DIV_B)
) (
  input  logic            clk_i,
  input  logic            sel_i,
  input  logic [KeyW-1:0] din_i,
  output logic [RW-1:0]   rem_o
);

  localparam int PW  = 2 * KeyW + 1;
  localparam int ShA = KeyW + $clog2(DIV_A);
  localparam int ShB = KeyW + $clog2(DIV_B);
  localparam logic [KeyW:0] RecipA = (KeyW+1)'(((64'd1 << ShA) / 64'(DIV_A)) + 64'd1);
  localparam logic [KeyW:0] RecipB = (KeyW+1)'(((64'd1 << ShB) / 64'(DIV_B)) + 64'd1);
  localparam logic [RW-1:0] DivA   = RW'(DIV_A);
  localparam logic [RW-1:0] DivB   = RW'(DIV_B);

  logic [PW-1:0]   prod_q;
  logic [KeyW-1:0] din_q;
  logic            sel_q;
  logic [KeyW:0]   recip;
  logic [KeyW-1:0] quo;
  logic [RW-1:0]   qd;

  assign recip = (sel_i == SelStep) ? RecipB : RecipA;

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(din_i) * PW'(recip);
    din_q  <= din_i;
    sel_q  <= sel_i;
  end

  // remainder is below the divisor, so only the low bits are needed
  assign quo   = (sel_q == SelStep) ? KeyW'(prod_q >> ShB) : KeyW'(prod_q >> ShA);
  assign qd    = RW'(quo) * ((sel_q == SelStep) ? DivB : DivA);
  assign rem_o = din_q[RW-1:0] - qd;

endmodule

// ===== hdl/double_hash_table.sv =====
// double hash table top level: sequencer, shared remainder unit, slot ram
// depends on dht_pkg, dht_mod_unit, dht_ram, double_hash_table_assert.svh
//
//  channel | direction | handshake               | fields
//  in      | input     | in_valid_i / in_stall_o  | kind_i, key_i
//  out     | output    | out_valid_o / out_stall_i | status_o, slot_o
//
// a word passes three remainder steps (S_MODK, S_MODX, S_MODS), a read setup (S_STEP),
// one probe per visited slot (1 to TABLE_SLOTS, in S_CHK) and S_RESP, which registers
// the result once the out register is free; the next word is accepted in S_IDLE after that
// after reset a clearing pass (S_CLR) empties every slot
// in_stall_o stays high from accept until the result is in the out register
// a waiting result does not block the next word until that one finishes
`include "double_hash_table_assert.svh"

module double_hash_table
  import dht_pkg::*;
#(
  parameter int TABLE_SLOTS  = DhtSlots,
  parameter int STEP_MODULUS = DhtStepMod
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KindW-1:0]   kind_i,
  input  logic [KeyW-1:0]    key_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatusW-1:0] status_o,
  output logic [SlotW-1:0]   slot_o
);

  localparam int IW   = $clog2(TABLE_SLOTS);
  localparam int MW   = $clog2(STEP_MODULUS);
  localparam int SW   = $clog2(STEP_MODULUS + 1);
  localparam int RemW = (IW > MW) ? IW : MW;
  localparam int RamW = KeyW + 1;

  state_e state_q, state_d;

  logic [IW-1:0]      cnt_q, cnt_d;
  logic [KindW-1:0]   kind_q, kind_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [IW-1:0]      step_q, step_d;
  logic [StatusW-1:0] res_status_q, res_status_d;
  logic [IW-1:0]      res_slot_q, res_slot_d;
  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [SlotW-1:0]   slot_q, slot_d;

  logic            mod_sel;
  logic [KeyW-1:0] mod_din;
  logic [RemW-1:0] mod_rem;

  logic            ram_we;
  logic [IW-1:0]   ram_addr;
  logic [RamW-1:0] ram_wdata, ram_rdata;

  logic            in_acc, is_ins, is_del, hit, last_probe, out_free;
  logic [IW:0]     sum, sum_w;
  logic [IW-1:0]   idx_n;
  logic [SW-1:0]   sval;
  logic [IW+SlotW-1:0] slot_ext;

  dht_mod_unit #(
    .DIV_A(TABLE_SLOTS),
    .DIV_B(STEP_MODULUS),
    .RW   (RemW)
  ) u_mod (
    .clk_i(clk_i),
    .sel_i(mod_sel),
    .din_i(mod_din),
    .rem_o(mod_rem)
  );

  dht_ram #(
    .WIDTH(RamW),
    .DEPTH(TABLE_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_ins     = (kind_q == KindInsert);
  assign is_del     = (kind_q == KindDelete);
  assign hit        = is_ins ? !ram_rdata[KeyW]
                             : (ram_rdata[KeyW] && (ram_rdata[KeyW-1:0] == key_q));
  assign last_probe = (cnt_q == IW'(TABLE_SLOTS - 1));
  assign out_free   = !out_valid_q || !out_stall_i;

  assign sum   = {1'b0, idx_q} + {1'b0, step_q};
  assign sum_w = (sum >= (IW+1)'(TABLE_SLOTS)) ? (sum - (IW+1)'(TABLE_SLOTS)) : sum;
  assign idx_n = sum_w[IW-1:0];
  assign sval  = SW'(STEP_MODULUS) - SW'(mod_rem[MW-1:0]);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR: begin
        if (last_probe) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) state_d = S_MODK;
      end
      S_MODK: state_d = S_MODX;
      S_MODX: state_d = S_MODS;
      S_MODS: state_d = S_STEP;
      S_STEP: state_d = S_CHK;
      S_CHK: begin
        if (hit || last_probe) state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and control
  always_comb begin
    cnt_d        = cnt_q;
    kind_d       = kind_q;
    key_d        = key_q;
    idx_d        = idx_q;
    step_d       = step_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    status_d     = status_q;
    slot_d       = slot_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mod_sel      = SelSlots;
    mod_din      = key_q;
    ram_we       = 1'b0;
    ram_addr     = idx_q;
    ram_wdata    = {1'b0, key_q};
    slot_ext     = {{SlotW{1'b0}}, res_slot_q};
    unique case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = cnt_q;
        ram_wdata = '0;
        cnt_d     = cnt_q + 1'b1;
      end
      S_IDLE: begin
        if (in_acc) begin
          kind_d = kind_i;
          key_d  = key_i;
        end
      end
      S_MODK: begin
        // key mod table size issued with the default select
      end
      S_MODX: begin
        idx_d   = mod_rem[IW-1:0];
        mod_sel = SelStep;
      end
      S_MODS: begin
        mod_sel = SelSlots;
        mod_din = KeyW'(sval);
      end
      S_STEP: begin
        step_d   = mod_rem[IW-1:0];
        cnt_d    = '0;
        ram_addr = idx_q;
      end
      S_CHK: begin
        if (hit) begin
          ram_we       = is_ins || is_del;
          ram_addr     = idx_q;
          ram_wdata    = {is_ins, key_q};
          res_status_d = StDone;
          res_slot_d   = idx_q;
        end else if (last_probe) begin
          res_status_d = is_ins ? StFull : StMissing;
          res_slot_d   = '0;
        end else begin
          ram_addr = idx_n;
          idx_d    = idx_n;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          slot_d      = slot_ext[SlotW-1:0];
        end
      end
      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    key_q        <= key_d;
    idx_q        <= idx_d;
    step_q       <= step_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    status_q     <= status_d;
    slot_q       <= slot_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;

  `DHT_ASSERT(a_idx_range, (state_q != S_CHK) || (idx_q <= IW'(TABLE_SLOTS - 1)),
    "probe index out of table range")
  `DHT_ASSERT(a_we_state, !ram_we || state_q == S_CLR || state_q == S_CHK,
    "ram written outside clear or probe")
  `DHT_ASSERT_NEXT(a_acc_start, in_acc, state_q == S_MODK,
    "accepted word did not start key reduction")
  `DHT_ASSERT(a_out_src, !$rose(out_valid_q) || $past(state_q) == S_RESP,
    "result shown without a finished probe")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for double_hash_table: queued directed and random words,
// a mirror of the slot table predicts status and slot for every word
// depends on dht_pkg and the double_hash_table rtl
module testbench;
  import dht_pkg::*;

  localparam logic [KindW-1:0] KindUndef = 2'd3;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [KeyW-1:0]  key;
    logic             drain;
  } op_word_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot;
  } outcome_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [KindW-1:0]   kind_i = KindInsert;
  logic [KeyW-1:0]    key_i = '0;
  logic               out_valid_o;
  wire                out_stall_i;
  logic [StatusW-1:0] status_o;
  logic [SlotW-1:0]   slot_o;

  logic rx_idle = 1'b0;
  logic long_hold = 1'b0;
  assign out_stall_i = rx_idle | long_hold;

  double_hash_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .key_i      (key_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .slot_o     (slot_o)
  );

  op_word_t       op_q[$];
  outcome_t       outcome_q[$];
  logic [KeyW-1:0] mirror_key[DhtSlots];
  logic           mirror_used[DhtSlots];

  int   n_items = 0;
  int   n_acc = 0;
  int   sent_cnt = 0;
  int   got_cnt = 0;
  int   errors = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   hold_cnt = 0;
  bit   hold_done = 1'b0;
  bit   offering = 1'b0;
  logic all_sent = 1'b0;
  op_word_t cur;

  function automatic void predict_outcome(input logic [KindW-1:0] op,
                                          input logic [KeyW-1:0] k);
    int unsigned kv;
    int unsigned pos;
    int unsigned stride;
    bit          hit;
    outcome_t    res;
    kv = k;
    pos = kv % DhtSlots;
    stride = (DhtStepMod - kv % DhtStepMod) % DhtSlots;
    hit = 1'b0;
    for (int i = 0; i < DhtSlots; i++) begin
      if (!hit) begin
        if (op == KindInsert) begin
          if (!mirror_used[pos]) begin
            mirror_used[pos] = 1'b1;
            mirror_key[pos] = k;
            hit = 1'b1;
          end
        end else if (mirror_used[pos] && mirror_key[pos] == k) begin
          if (op == KindDelete) mirror_used[pos] = 1'b0;
          hit = 1'b1;
        end
        if (!hit) pos = (pos + stride) % DhtSlots;
      end
    end
    res.status = hit ? StDone : ((op == KindInsert) ? StFull : StMissing);
    res.slot = hit ? SlotW'(pos) : '0;
    outcome_q.push_back(res);
  endfunction

  task automatic push_op(input logic [KindW-1:0] op, input logic [KeyW-1:0] k);
    op_word_t w;
    w.kind = op;
    w.key = k;
    w.drain = 1'b0;
    op_q.push_back(w);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_outcome(kind_i, key_i);
        n_acc++;
        offering = 1'b0;
        if (n_acc < n_items - 120 && (n_acc / 100) % 4 != 3 && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 11);
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (op_q.size() > 0 && !(op_q[0].drain && n_acc != got_cnt)) begin
          cur = op_q.pop_front();
          kind_i <= cur.kind;
          key_i <= cur.key;
          offering = 1'b1;
        end
      end
      in_valid_i <= offering;
      sent_cnt <= n_acc;
      all_sent <= (op_q.size() == 0) && !offering;
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (got_cnt >= sent_cnt) begin
          $display("%0t: unexpected word, expected none, actual status %0d slot %0d",
                   $time, status_o, slot_o);
          errors++;
        end else begin
          if (status_o !== outcome_q[got_cnt].status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, outcome_q[got_cnt].status, status_o);
            errors++;
          end
          if (slot_o !== outcome_q[got_cnt].slot) begin
            $display("%0t: slot mismatch, expected %0d, actual %0d",
                     $time, outcome_q[got_cnt].slot, slot_o);
            errors++;
          end
          got_cnt <= got_cnt + 1;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rx_idle <= 1'b1;
      end else if (sent_cnt < n_items - 120 && (sent_cnt / 100) % 4 != 1 &&
                   $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        rx_idle <= 1'b1;
      end else begin
        rx_idle <= 1'b0;
      end
    end
  end

  // long receiver hold so the input side backs up
  always @(posedge clk_i) begin
    if (rst_ni && !hold_done && sent_cnt >= 300) begin
      if (hold_cnt < 400) begin
        hold_cnt++;
        long_hold <= 1'b1;
      end else begin
        hold_done = 1'b1;
        long_hold <= 1'b0;
      end
    end
  end

  initial begin : stim
    logic [KeyW-1:0] pool[12];
    logic [KeyW-1:0] k;
    logic [KindW-1:0] op;
    int seg_len;
    int mode;
    int r;
    int p_ins;
    int p_del;
    int p_srch;

    for (int i = 0; i < DhtSlots; i++) begin
      mirror_key[i] = '0;
      mirror_used[i] = 1'b0;
    end

    // directed: key extremes, every kind, duplicates, short probe cycle
    push_op(KindInsert, '0);
    push_op(KindInsert, {KeyW{1'b1}});
    push_op(KindSearch, {KeyW{1'b1}});
    push_op(KindUndef, '0);
    push_op(KindDelete, '0);
    push_op(KindSearch, '0);
    push_op(KindDelete, '0);
    push_op(KindInsert, 31'd5);
    push_op(KindInsert, 31'd5);
    push_op(KindSearch, 31'd5);
    push_op(KindDelete, 31'd5);
    push_op(KindSearch, 31'd5);
    push_op(KindDelete, 31'd5);
    push_op(KindDelete, {KeyW{1'b1}});
    // step of four only reaches four slots
    for (int i = 0; i < 5; i++) push_op(KindInsert, 31'd80);
    push_op(KindSearch, 31'd80);
    push_op(KindUndef, 31'd12345);
    push_op(KindDelete, 31'h2AAA_AAAA);
    push_op(KindSearch, 31'h5555_5555);

    while (op_q.size() < 900) begin
      for (int i = 0; i < 12; i++) begin
        r = $urandom_range(0, (i == 0) ? 2 : 3);
        if (r == 0) pool[i] = KeyW'($urandom_range(0, 40));
        else if (r == 1) pool[i] = KeyW'($urandom);
        else if (r == 2) pool[i] = {KeyW{1'b1}} - KeyW'($urandom_range(0, 40));
        else pool[i] = pool[0] + 31'(16 * $urandom_range(1, 20));
      end
      seg_len = $urandom_range(20, 60);
      mode = $urandom_range(0, 2);
      p_ins = (mode == 0) ? 60 : (mode == 1) ? 20 : 35;
      p_del = p_ins + ((mode == 0) ? 15 : (mode == 1) ? 50 : 30);
      p_srch = p_del + ((mode == 0) ? 20 : (mode == 1) ? 25 : 30);
      for (int j = 0; j < seg_len; j++) begin
        r = $urandom_range(0, 99);
        op = (r < p_ins) ? KindInsert : (r < p_del) ? KindDelete :
             (r < p_srch) ? KindSearch : KindUndef;
        if ($urandom_range(0, 9) == 0) k = KeyW'($urandom);
        else k = pool[$urandom_range(0, 11)];
        push_op(op, k);
      end
    end
    op_q[500].drain = 1'b1;
    n_items = op_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!all_sent || got_cnt != sent_cnt) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("** double_hash_table: PASSED **");
    end else begin
      $display("** double_hash_table: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** double_hash_table: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/dht_pkg.sv
hdl/dht_ram.sv
hdl/dht_mod_unit.sv
hdl/double_hash_table.sv
dv/testbench.sv
